// ===== hw/rtl/calendar_seconds_converter_top_macros.svh =====
// Assertion macros shared by the calendar/seconds converter RTL
`ifndef CALENDAR_SECONDS_CONVERTER_TOP_MACROS_SVH
`define CALENDAR_SECONDS_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CSC_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define CSC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define CSC_ASSERT(label, cond, msg)
`define CSC_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/csc_pkg.sv =====
// Types, constants and month table for the calendar/seconds converter
package csc_pkg;

	localparam logic ACT_DATE2SEC = 1'b0;
	localparam logic ACT_SEC2DATE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] seconds_in;
		logic [7:0]  year_in;
		logic [7:0]  month_in;
		logic [7:0]  day_in;
		logic [7:0]  hour_in;
		logic [7:0]  minute_in;
		logic [7:0]  second_in;
	} req_t;

	typedef struct packed {
		logic [31:0] seconds_out;
		logic [6:0]  year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic [2:0]  weekday;
		logic        range_error;
	} rsp_t;

	// stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// date and time as produced by either conversion path
	typedef struct packed {
		logic [31:0] seconds;
		logic [6:0]  year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        err;
	} cal_res_t;

	// days before the first of month m in a common year
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/csc_date_path.sv =====
// Date to seconds path: range check and day count, then the seconds sum
module csc_date_path (
	input  logic              clk,
	input  csc_pkg::pipe_en_t en,
	input  csc_pkg::req_t     req,
	output csc_pkg::cal_res_t res_s4
);
	import csc_pkg::*;

	logic [6:0]  y7;
	logic [3:0]  mo4;
	logic [4:0]  d5;
	logic [4:0]  h5;
	logic [5:0]  mi6;
	logic [5:0]  s6;
	logic        leap_c;
	logic        err_c;
	logic [15:0] days_c;
	logic [31:0] tod_c;
	cal_res_t    res2_c;

	logic [15:0] days_s1;
	logic [31:0] tod_s1;
	cal_res_t    res_s1;
	cal_res_t    res_s2;
	cal_res_t    res_s3;

	assign y7  = req.year_in[6:0];
	assign mo4 = req.month_in[3:0];
	assign d5  = req.day_in[4:0];
	assign h5  = req.hour_in[4:0];
	assign mi6 = req.minute_in[5:0];
	assign s6  = req.second_in[5:0];

	always_comb begin
		err_c = (req.year_in > 8'd99) || (req.month_in == 8'd0) || (req.month_in > 8'd12) ||
			(req.day_in == 8'd0) || (req.day_in > 8'd31) || (req.hour_in > 8'd23) ||
			(req.minute_in > 8'd59) || (req.second_in > 8'd59);
		leap_c = (y7[1:0] == 2'd0) && (mo4 > 4'd2);
		days_c = 16'(y7) * 16'd365 + 16'((8'(y7) + 8'd3) >> 2) + 16'(month_start(mo4)) +
			16'(d5) - 16'd1 + 16'(leap_c);
		// time of day, less the one-day epoch offset, mod 2^32
		tod_c = 32'(h5) * 32'd3600 + 32'(mi6) * 32'd60 + 32'(s6) - 32'd86400;
	end

	always_comb begin
		res2_c         = res_s1;
		res2_c.seconds = 32'(days_s1) * 32'd86400 + tod_s1;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			days_s1        <= days_c;
			tod_s1         <= tod_c;
			res_s1.seconds <= 32'd0;
			res_s1.year    <= y7;
			res_s1.month   <= mo4;
			res_s1.day     <= d5;
			res_s1.hour    <= h5;
			res_s1.minute  <= mi6;
			res_s1.second  <= s6;
			res_s1.err     <= err_c;
		end
		if (en.s2) begin
			res_s2 <= res2_c;
		end
		if (en.s3) begin
			res_s3 <= res_s2;
		end
		if (en.s4) begin
			res_s4 <= res_s3;
		end
	end

endmodule

// ===== hw/rtl/csc_secs_path.sv =====
// Seconds to date path: day split, four-year cycle, month search, time of day
module csc_secs_path (
	input  logic              clk,
	input  csc_pkg::pipe_en_t en,
	input  logic [31:0]       seconds_in,
	output csc_pkg::cal_res_t res_s4
);
	import csc_pkg::*;

	// reciprocals: secs/86400 = (secs>>7)/675, days/1461, rem/3600, rem/60
	localparam logic [26:0] RCP_675  = 27'd101806633;
	localparam logic [16:0] RCP_1461 = 17'd91868;
	localparam logic [17:0] RCP_3600 = 18'd149131;
	localparam logic [17:0] RCP_60   = 18'd139811;

	// stage 1
	logic [51:0] qprod_c;
	logic [15:0] q_s1;
	logic [31:0] secs_s1;

	// stage 2
	logic [15:0] days_c;
	logic [32:0] cprod_c;
	logic [31:0] rem32_c;
	logic [16:0] rem_s2;
	logic [15:0] days_s2;
	logic [5:0]  c_s2;
	logic [31:0] secs_s2;

	// stage 3
	logic [10:0] cyc_c;
	logic [1:0]  yo_c;
	logic [10:0] doy11_c;
	logic [33:0] hprod_c;
	logic [33:0] mprod_c;
	logic [7:0]  year_s3;
	logic [8:0]  doy_s3;
	logic        leap_s3;
	logic [4:0]  hour_s3;
	logic [10:0] mod_s3;
	logic [16:0] rem_s3;
	logic [31:0] secs_s3;

	// stage 4
	logic        feb29_c;
	logic [8:0]  dadj_c;
	logic [3:0]  m_c;
	logic [4:0]  dd_c;
	logic [10:0] minute_c;
	logic [16:0] second_c;

	assign qprod_c = 52'(seconds_in[31:7]) * 52'(RCP_675);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			q_s1    <= qprod_c[51:36];
			secs_s1 <= seconds_in;
		end
	end

	always_comb begin
		days_c  = q_s1 + 16'd1;
		cprod_c = 33'(days_c) * 33'(RCP_1461);
		rem32_c = secs_s1 - 32'(q_s1) * 32'd86400;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			rem_s2  <= rem32_c[16:0];
			days_s2 <= days_c;
			c_s2    <= cprod_c[32:27];
			secs_s2 <= secs_s1;
		end
	end

	always_comb begin
		cyc_c = 11'(days_s2 - 16'(c_s2) * 16'd1461);
		if (cyc_c < 11'd366) begin
			yo_c    = 2'd0;
			doy11_c = cyc_c;
		end else if (cyc_c < 11'd731) begin
			yo_c    = 2'd1;
			doy11_c = cyc_c - 11'd366;
		end else if (cyc_c < 11'd1096) begin
			yo_c    = 2'd2;
			doy11_c = cyc_c - 11'd731;
		end else begin
			yo_c    = 2'd3;
			doy11_c = cyc_c - 11'd1096;
		end
		hprod_c = 34'(rem_s2) * 34'(RCP_3600);
		mprod_c = 34'(rem_s2) * 34'(RCP_60);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			year_s3 <= {c_s2, 2'b00} + 8'(yo_c);
			doy_s3  <= doy11_c[8:0];
			leap_s3 <= (yo_c == 2'd0);
			hour_s3 <= hprod_c[33:29];
			mod_s3  <= mprod_c[33:23];
			rem_s3  <= rem_s2;
			secs_s3 <= secs_s2;
		end
	end

	always_comb begin
		feb29_c = leap_s3 && (doy_s3 == 9'd59);
		dadj_c  = doy_s3 - 9'(leap_s3 && (doy_s3 > 9'd59));
		m_c     = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (dadj_c >= month_start(4'(k))) begin
				m_c = 4'(k);
			end
		end
		dd_c = 5'(dadj_c - month_start(m_c) + 9'd1);
		if (feb29_c) begin
			m_c  = 4'd2;
			dd_c = 5'd29;
		end
		minute_c = mod_s3 - 11'(hour_s3) * 11'd60;
		second_c = rem_s3 - 17'(mod_s3) * 17'd60;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			res_s4.seconds <= secs_s3;
			res_s4.year    <= year_s3[6:0];
			res_s4.month   <= m_c;
			res_s4.day     <= dd_c;
			res_s4.hour    <= hour_s3;
			res_s4.minute  <= minute_c[5:0];
			res_s4.second  <= second_c[5:0];
			res_s4.err     <= (year_s3 > 8'd99);
		end
	end

endmodule

// ===== hw/rtl/csc_out_stage.sv =====
// Output stage: path select, error zeroing and weekday
module csc_out_stage (
	input  logic              clk,
	input  logic              en,
	input  logic              action,
	input  csc_pkg::cal_res_t date_res,
	input  csc_pkg::cal_res_t secs_res,
	output csc_pkg::rsp_t     rsp_s5
);
	import csc_pkg::*;

	cal_res_t   sel_c;
	logic [7:0] yt_c;
	logic [7:0] sum_c;
	logic [4:0] fold1_c;
	logic [3:0] fold2_c;
	logic [2:0] r_c;
	logic [2:0] wd_c;
	rsp_t       rsp_c;

	// 2*mm + 3*(mm+1)/5 with January and February counted as months 13 and 14
	function automatic logic [5:0] month_term(input logic [3:0] m);
		logic [5:0] r;
		case (m)
			4'd1:    r = 6'd34;
			4'd2:    r = 6'd37;
			4'd3:    r = 6'd8;
			4'd4:    r = 6'd11;
			4'd5:    r = 6'd13;
			4'd6:    r = 6'd16;
			4'd7:    r = 6'd18;
			4'd8:    r = 6'd21;
			4'd9:    r = 6'd24;
			4'd10:   r = 6'd26;
			4'd11:   r = 6'd29;
			4'd12:   r = 6'd31;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	always_comb begin
		sel_c = (action == ACT_SEC2DATE) ? secs_res : date_res;
		// year term biased by 7 so it never goes negative; Jan/Feb of year 0 use year -1
		if (sel_c.month <= 4'd2) begin
			if (sel_c.year == 7'd0) begin
				yt_c = 8'd5;
			end else begin
				yt_c = 8'(sel_c.year - 7'd1) + 8'((sel_c.year - 7'd1) >> 2) + 8'd7;
			end
		end else begin
			yt_c = 8'(sel_c.year) + 8'(sel_c.year >> 2) + 8'd7;
		end
		sum_c   = 8'(sel_c.day) + 8'(month_term(sel_c.month)) + yt_c;
		// mod 7 by folding octal digits (8 = 1 mod 7)
		fold1_c = 5'(sum_c[7:6]) + 5'(sum_c[5:3]) + 5'(sum_c[2:0]);
		fold2_c = 4'(fold1_c[4:3]) + 4'(fold1_c[2:0]);
		r_c     = (fold2_c >= 4'd7) ? 3'(fold2_c - 4'd7) : fold2_c[2:0];
		wd_c    = (r_c == 3'd6) ? 3'd0 : r_c + 3'd1;

		if (sel_c.err) begin
			rsp_c             = '0;
			rsp_c.range_error = 1'b1;
		end else begin
			rsp_c.seconds_out = sel_c.seconds;
			rsp_c.year_out    = sel_c.year;
			rsp_c.month_out   = sel_c.month;
			rsp_c.day_out     = sel_c.day;
			rsp_c.hour_out    = sel_c.hour;
			rsp_c.minute_out  = sel_c.minute;
			rsp_c.second_out  = sel_c.second;
			rsp_c.weekday     = wd_c;
			rsp_c.range_error = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s5 <= rsp_c;
		end
	end

endmodule

// ===== hw/rtl/calendar_seconds_converter_top.sv =====
// Top level of the calendar/seconds converter: valid chain and stage enables
// An accepted request passes through register stages s1 to s5 to its response on rsp.
// Throughput: one request per cycle while rsp_stall is low; the five register stages run in parallel.
// Each stage loads when empty or when the next stage moves, so bubbles close up.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data regs are not reset.
`include "calendar_seconds_converter_top_macros.svh"

module calendar_seconds_converter_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  csc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output csc_pkg::rsp_t rsp
);
	import csc_pkg::*;

	pipe_en_t en;
	logic     valid_s1;
	logic     valid_s2;
	logic     valid_s3;
	logic     valid_s4;
	logic     valid_s5;
	logic     action_s1;
	logic     action_s2;
	logic     action_s3;
	logic     action_s4;
	cal_res_t date_res_s4;
	cal_res_t secs_res_s4;

	always_comb begin
		en.s5 = !valid_s5 || !rsp_stall;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign req_stall = !en.s1;
	assign rsp_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= req_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) action_s1 <= req.action;
		if (en.s2) action_s2 <= action_s1;
		if (en.s3) action_s3 <= action_s2;
		if (en.s4) action_s4 <= action_s3;
	end

	csc_date_path u_date_path (
		.clk    (clk),
		.en     (en),
		.req    (req),
		.res_s4 (date_res_s4)
	);

	csc_secs_path u_secs_path (
		.clk        (clk),
		.en         (en),
		.seconds_in (req.seconds_in),
		.res_s4     (secs_res_s4)
	);

	csc_out_stage u_out_stage (
		.clk      (clk),
		.en       (en.s5),
		.action   (action_s4),
		.date_res (date_res_s4),
		.secs_res (secs_res_s4),
		.rsp_s5   (rsp)
	);

	`CSC_ASSERT_IMP(a_stall_needs_full, req_stall, valid_s1, "request stalled with stage 1 empty")
	`CSC_ASSERT_IMP(a_err_zero, rsp_valid && rsp.range_error, rsp.seconds_out == 32'd0 && rsp.month_out == 4'd0 && rsp.weekday == 3'd0, "error response not zeroed")
	`CSC_ASSERT_IMP(a_date_ok, rsp_valid && !rsp.range_error, rsp.month_out != 4'd0 && rsp.month_out <= 4'd12 && rsp.day_out != 5'd0, "bad month or day")
	`CSC_ASSERT_IMP(a_weekday, rsp_valid, rsp.weekday <= 3'd6, "weekday out of range")

endmodule
